// ----- rtl/core/cppm_pkg.sv -----
// Shared constants and types for the convex polygon pixel mask.
// No dependencies; imported by cppm_mul and convex_polygon_pixel_mask.
`default_nettype none

package cppm_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);

    localparam int CMD_W   = 2;
    localparam int COORD_W = 20;
    localparam int PIX_W   = 15;
    localparam int DIFF_W  = COORD_W + 1;   // exact difference of two coordinates
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_CLEAR  = 2'd0;
    localparam cmd_t CMD_APPEND = 2'd1;
    localparam cmd_t CMD_TEST   = 2'd2;

    // operands for the shared unit: (u0 - v0) * (u1 - v1)
    typedef struct packed {
        logic signed [DIFF_W-1:0] u0;
        logic signed [DIFF_W-1:0] v0;
        logic signed [DIFF_W-1:0] u1;
        logic signed [DIFF_W-1:0] v1;
    } mul_op_t;

endpackage

`default_nettype wire

// ----- rtl/core/cppm_mul.sv -----
// Shared difference-times-difference unit, one registered product per cycle.
// Depends on cppm_pkg.
`default_nettype none

module cppm_mul (
    input  wire logic                             aclk,
    input  wire cppm_pkg::mul_op_t                op_i,
    output logic signed [cppm_pkg::PROD_W-1:0]    prod_o
);
    import cppm_pkg::*;

    logic signed [DIFF_W-1:0] da;
    logic signed [DIFF_W-1:0] db;
    logic signed [PROD_W-1:0] prod_reg;

    // operands arrive extended to DIFF_W (pixel zero-extended, vertices sign-extended), so the differences are exact
    assign da = op_i.u0 - op_i.v0;
    assign db = op_i.u1 - op_i.v1;

    always_ff @(posedge aclk) begin
        prod_reg <= da * db;
    end

    assign prod_o = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/core/convex_polygon_pixel_mask.sv -----
// Convex polygon pixel mask: clear and append are taken in S_IDLE and give no result.
// A test with N stored vertices (N >= 2) holds the input through S_FETCH, S_PREV,
// then S_MUL1, S_MUL2, S_CMP per edge and S_DONE; with N < 2 only S_DONE.
// The per-edge states come from the single shared multiplier (two products,
// then the compare) and the vertex memory with its single registered read port.
// aresetn (sync, active low) empties the list and drops any pending result.
`default_nettype none

module convex_polygon_pixel_mask (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [cppm_pkg::CMD_W-1:0]          s_command,
    input  wire logic signed [cppm_pkg::COORD_W-1:0] s_vert_x,
    input  wire logic signed [cppm_pkg::COORD_W-1:0] s_vert_y,
    input  wire logic [cppm_pkg::PIX_W-1:0]          s_pixel_x,
    input  wire logic [cppm_pkg::PIX_W-1:0]          s_pixel_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_inside_res
);
    import cppm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_PREV,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [VCNT_W-1:0]         vcount_reg, vcount_next;
    logic [VCNT_W-1:0]         k_reg, k_next;
    logic [PIX_W-1:0]          px_reg, px_next;
    logic [PIX_W-1:0]          py_reg, py_next;
    logic signed [COORD_W-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_W-1:0] prev_y_reg, prev_y_next;
    logic signed [PROD_W-1:0]  prod1_reg, prod1_next;
    logic                      inside_reg, inside_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_inside_reg, m_inside_next;

    // vertex memory, registered read at the current edge index
    logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
    logic signed [COORD_W-1:0] rd_x_reg;
    logic signed [COORD_W-1:0] rd_y_reg;
    logic                      wr_en;

    mul_op_t                   mul_op;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [CROSS_W-1:0] cross_sum;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[vcount_reg[VIDX_W-1:0]] <= s_vert_x;
            mem_y[vcount_reg[VIDX_W-1:0]] <= s_vert_y;
        end
        rd_x_reg <= mem_x[k_reg[VIDX_W-1:0]];
        rd_y_reg <= mem_y[k_reg[VIDX_W-1:0]];
    end

    // first product uses (px - x0)*(y1 - y0), second (py - y0)*(x1 - x0)
    always_comb begin
        if (state_reg == S_MUL1) begin
            mul_op.u0 = {{(DIFF_W-PIX_W){1'b0}}, px_reg};
            mul_op.v0 = {prev_x_reg[COORD_W-1], prev_x_reg};
            mul_op.u1 = {rd_y_reg[COORD_W-1], rd_y_reg};
            mul_op.v1 = {prev_y_reg[COORD_W-1], prev_y_reg};
        end else begin
            mul_op.u0 = {{(DIFF_W-PIX_W){1'b0}}, py_reg};
            mul_op.v0 = {prev_y_reg[COORD_W-1], prev_y_reg};
            mul_op.u1 = {rd_x_reg[COORD_W-1], rd_x_reg};
            mul_op.v1 = {prev_x_reg[COORD_W-1], prev_x_reg};
        end
    end

    cppm_mul u_mul (
        .aclk   (aclk),
        .op_i   (mul_op),
        .prod_o (mul_prod)
    );

    assign cross_sum = {prod1_reg[PROD_W-1], prod1_reg} - {mul_prod[PROD_W-1], mul_prod};

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        vcount_next   = vcount_reg;
        k_next        = k_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        prod1_next    = prod1_reg;
        inside_next   = inside_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_inside_next = m_inside_reg;
        wr_en         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        CMD_CLEAR: begin
                            vcount_next = '0;
                        end
                        CMD_APPEND: begin
                            if (vcount_reg < VCNT_W'(MAX_VERTICES)) begin
                                wr_en       = 1'b1;
                                vcount_next = vcount_reg + 1'b1;
                            end
                        end
                        CMD_TEST: begin
                            px_next     = s_pixel_x;
                            py_next     = s_pixel_y;
                            inside_next = 1'b1;
                            k_next      = '0;
                            if (vcount_reg < VCNT_W'(2)) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                k_next     = VCNT_W'(1);
                state_next = S_PREV;
            end
            S_PREV: begin
                prev_x_next = rd_x_reg;
                prev_y_next = rd_y_reg;
                state_next  = S_MUL1;
            end
            S_MUL1: begin
                state_next = S_MUL2;
            end
            S_MUL2: begin
                // bump the index here so the next vertex is read during S_CMP
                prod1_next = mul_prod;
                k_next     = k_reg + 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (cross_sum[CROSS_W-1]) begin
                    inside_next = 1'b0;
                end
                prev_x_next = rd_x_reg;
                prev_y_next = rd_y_reg;
                if (k_reg < vcount_reg) begin
                    state_next = S_MUL1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_inside_next = inside_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            vcount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vcount_reg  <= vcount_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg        <= k_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        prod1_reg    <= prod1_next;
        inside_reg   <= inside_next;
        m_inside_reg <= m_inside_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vcount_reg <= VCNT_W'(MAX_VERTICES))
        else $error("vertex count above table size");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL1 || state_reg == S_MUL2 || state_reg == S_CMP)
        |-> (k_reg <= vcount_reg && k_reg != '0))
        else $error("edge index outside stored vertices");

    a_few_vertices: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_TEST && vcount_reg < VCNT_W'(2))
        |=> (state_reg == S_DONE && inside_reg))
        else $error("test with fewer than two vertices not reported inside");

endmodule

`default_nettype wire
